@@ sv/hsd_pkg.sv @@
// shared types, constants and the microcode table of the heap sort block
package hsd_pkg;

    localparam int KEY_W     = 24;
    localparam int TAG_W     = 16;
    localparam int DEPTH_DEF = 64;
    localparam int STEP_W    = 5;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } rec_t;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_I_HALF,
        OP_BUILD_SETUP,
        OP_LD_CUR,
        OP_I_ALL,
        OP_LD_ROOT,
        OP_SWAP,
        OP_K_CLR,
        OP_EMIT,
        OP_FINISH,
        OP_PICK_L,
        OP_PICK_R,
        OP_WR_CUR
    } op_t;

    // memory read address select
    typedef enum logic [2:0] {
        ADDR_I_DEC,
        ADDR_ZERO,
        ADDR_LC,
        ADDR_RC,
        ADDR_K
    } addr_sel_t;

    // jump condition
    typedef enum logic [3:0] {
        COND_NEXT,
        COND_GOTO,
        COND_WAIT_LAST,
        COND_I_ZERO,
        COND_NO_LC,
        COND_MOVE,
        COND_BUSY,
        COND_MORE,
        COND_CALL,
        COND_RET
    } cond_t;

    typedef struct packed {
        op_t       op;
        addr_sel_t addr;
        cond_t     cond;
        step_t     target;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic last_acc;
        logic i_zero;
        logic no_lc;
        logic move;
        logic busy;
        logic more;
    } status_t;

    localparam step_t ST_LOAD        = step_t'(0);
    localparam step_t ST_BUILD_INIT  = step_t'(1);
    localparam step_t ST_BUILD_TEST  = step_t'(2);
    localparam step_t ST_BUILD_CUR   = step_t'(3);
    localparam step_t ST_BUILD_BACK  = step_t'(4);
    localparam step_t ST_SORT_INIT   = step_t'(5);
    localparam step_t ST_SORT_TEST   = step_t'(6);
    localparam step_t ST_SORT_RD0    = step_t'(7);
    localparam step_t ST_SORT_SWAP   = step_t'(8);
    localparam step_t ST_SORT_BACK   = step_t'(9);
    localparam step_t ST_EMIT_INIT   = step_t'(10);
    localparam step_t ST_EMIT_RD     = step_t'(11);
    localparam step_t ST_EMIT_LD     = step_t'(12);
    localparam step_t ST_FINISH      = step_t'(13);
    localparam step_t ST_SIFT_TEST   = step_t'(14);
    localparam step_t ST_SIFT_PICK_L = step_t'(15);
    localparam step_t ST_SIFT_PICK_R = step_t'(16);
    localparam step_t ST_SIFT_END    = step_t'(17);

    // control store
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            ST_LOAD:        w = '{OP_LOAD,        ADDR_ZERO,  COND_WAIT_LAST, ST_LOAD};
            ST_BUILD_INIT:  w = '{OP_I_HALF,      ADDR_ZERO,  COND_NEXT,      ST_LOAD};
            ST_BUILD_TEST:  w = '{OP_BUILD_SETUP, ADDR_I_DEC, COND_I_ZERO,    ST_SORT_INIT};
            ST_BUILD_CUR:   w = '{OP_LD_CUR,      ADDR_ZERO,  COND_CALL,      ST_SIFT_TEST};
            ST_BUILD_BACK:  w = '{OP_NONE,        ADDR_ZERO,  COND_GOTO,      ST_BUILD_TEST};
            ST_SORT_INIT:   w = '{OP_I_ALL,       ADDR_ZERO,  COND_NEXT,      ST_LOAD};
            ST_SORT_TEST:   w = '{OP_NONE,        ADDR_ZERO,  COND_I_ZERO,    ST_EMIT_INIT};
            ST_SORT_RD0:    w = '{OP_LD_ROOT,     ADDR_I_DEC, COND_NEXT,      ST_LOAD};
            ST_SORT_SWAP:   w = '{OP_SWAP,        ADDR_ZERO,  COND_CALL,      ST_SIFT_TEST};
            ST_SORT_BACK:   w = '{OP_NONE,        ADDR_ZERO,  COND_GOTO,      ST_SORT_TEST};
            ST_EMIT_INIT:   w = '{OP_K_CLR,       ADDR_ZERO,  COND_NEXT,      ST_LOAD};
            ST_EMIT_RD:     w = '{OP_NONE,        ADDR_K,     COND_BUSY,      ST_EMIT_RD};
            ST_EMIT_LD:     w = '{OP_EMIT,        ADDR_ZERO,  COND_MORE,      ST_EMIT_RD};
            ST_FINISH:      w = '{OP_FINISH,      ADDR_ZERO,  COND_GOTO,      ST_LOAD};
            ST_SIFT_TEST:   w = '{OP_NONE,        ADDR_LC,    COND_NO_LC,     ST_SIFT_END};
            ST_SIFT_PICK_L: w = '{OP_PICK_L,      ADDR_RC,    COND_NEXT,      ST_LOAD};
            ST_SIFT_PICK_R: w = '{OP_PICK_R,      ADDR_ZERO,  COND_MOVE,      ST_SIFT_TEST};
            ST_SIFT_END:    w = '{OP_WR_CUR,      ADDR_ZERO,  COND_RET,       ST_LOAD};
            default:        w = '{OP_NONE,        ADDR_ZERO,  COND_GOTO,      ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

@@ sv/hsd_in_if.sv @@
// record input channel
interface hsd_in_if;
    logic                       valid;
    logic                       ready;
    logic [hsd_pkg::KEY_W-1:0]  count_key;
    logic [hsd_pkg::TAG_W-1:0]  word_tag;
    logic                       is_last;

    modport source (output valid, count_key, word_tag, is_last, input ready);
    modport sink   (input valid, count_key, word_tag, is_last, output ready);
endinterface

@@ sv/hsd_out_if.sv @@
// sorted result channel
interface hsd_out_if;
    logic                       valid;
    logic                       ready;
    logic [hsd_pkg::KEY_W-1:0]  sorted_key;
    logic [hsd_pkg::TAG_W-1:0]  sorted_tag;
    logic                       last_out;
    logic                       overflowed;

    modport source (output valid, sorted_key, sorted_tag, last_out, overflowed, input ready);
    modport sink   (input valid, sorted_key, sorted_tag, last_out, overflowed, output ready);
endinterface

@@ sv/hsd_ram.sv @@
// generic single write port, single read port ram with registered read
module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/hsd_seq.sv @@
// microcode sequencer: step counter, return register and control store
module hsd_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  hsd_pkg::status_t status,
    output hsd_pkg::ucode_t  uword
);

    hsd_pkg::step_t step_reg, step_next;
    hsd_pkg::step_t ret_reg, ret_next;
    hsd_pkg::step_t step_inc;
    logic           take;

    assign uword    = hsd_pkg::ucode_rom(step_reg);
    assign step_inc = step_reg + hsd_pkg::step_t'(1);

    always_comb
    begin
        case (uword.cond)
            hsd_pkg::COND_NEXT:      take = 1'b0;
            hsd_pkg::COND_GOTO:      take = 1'b1;
            hsd_pkg::COND_WAIT_LAST: take = !status.last_acc;
            hsd_pkg::COND_I_ZERO:    take = status.i_zero;
            hsd_pkg::COND_NO_LC:     take = status.no_lc;
            hsd_pkg::COND_MOVE:      take = status.move;
            hsd_pkg::COND_BUSY:      take = status.busy;
            hsd_pkg::COND_MORE:      take = status.more;
            hsd_pkg::COND_CALL:      take = 1'b1;
            hsd_pkg::COND_RET:       take = 1'b1;
            default:                 take = 1'b0;
        endcase

        ret_next = ret_reg;
        if (uword.cond == hsd_pkg::COND_CALL)
        begin
            ret_next = step_inc;
        end

        if (!take)
        begin
            step_next = step_inc;
        end
        else if (uword.cond == hsd_pkg::COND_RET)
        begin
            step_next = ret_reg;
        end
        else
        begin
            step_next = uword.target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= hsd_pkg::ST_LOAD;
            ret_reg  <= hsd_pkg::ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
            ret_reg  <= ret_next;
        end
    end

endmodule

@@ sv/heap_sort_descending.sv @@
// heap sort block: loads records, sorts them by key with a min-heap, emits them descending
//
// usage
// - records: one transaction per record (count_key, word_tag, is_last). records are
//   taken one per cycle while the block is loading; is_last closes the set and
//   starts the sort. records past DEPTH are dropped and flag overflowed on the run
// - sorted: one transaction per stored record, largest key first, last_out on the
//   final one; overflowed is the same on every result of a run
// - work for a set of n records: a sift-down descends the heap one level at a time
//   and ends at a leaf or above one; the heap build runs n/2 sifts, the sort
//   phase runs n sifts, and emission reads and registers one result at a time;
//   the single read port of the record memory sets the pace
// - the input is not ready from the last record of a set until the finish step,
//   which follows the final result's emit step, is over; then the next set loads
// - a stalled receiver holds the output register and the sequencer waits in its
//   emit step; nothing is lost
// - reset (rst_n, asynchronous) empties the set and clears the overflow flag and
//   the output valid; the record memory is not cleared, only written entries are read
module heap_sort_descending #(
    parameter int DEPTH = hsd_pkg::DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hsd_in_if.sink       records,
    hsd_out_if.source    sorted
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsd_pkg::ucode_t  uword;
    hsd_pkg::status_t status;

    // record memory port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    hsd_pkg::rec_t     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    hsd_pkg::rec_t     rd_rec;

    // set bookkeeping
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;

    // heap walk registers
    logic [CW-1:0]     i_reg, i_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     len_reg, len_next;
    hsd_pkg::rec_t     cur_reg, cur_next;
    hsd_pkg::rec_t     best_reg, best_next;
    logic [AW-1:0]     pick_reg, pick_next;
    logic [AW-1:0]     k_reg, k_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    hsd_pkg::rec_t     out_rec_reg, out_rec_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              in_acc;
    logic              room;
    hsd_pkg::rec_t     in_rec;
    logic [CW:0]       lc;
    logic [CW:0]       rc;
    logic              rc_ok;
    logic [CW-1:0]     i_dec;
    logic [CW-1:0]     k_inc;
    logic              take_r;
    hsd_pkg::rec_t     fin_rec;
    logic [AW-1:0]     fin_pick;

    hsd_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    hsd_ram #(
        .WIDTH ($bits(hsd_pkg::rec_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_rec)
    );

    // input side: ready only in the load step
    assign records.ready = (uword.op == hsd_pkg::OP_LOAD);
    assign in_acc        = records.valid && records.ready;
    assign in_rec        = '{key: records.count_key, tag: records.word_tag};
    assign room          = count_reg < CW'(DEPTH);

    // heap index arithmetic
    assign lc    = ((CW + 1)'(pos_reg) << 1) | (CW + 1)'(1);
    assign rc    = lc + (CW + 1)'(1);
    assign rc_ok = rc < {1'b0, len_reg};
    assign i_dec = i_reg - CW'(1);
    assign k_inc = CW'(k_reg) + CW'(1);

    // right child compare against the winner of the left compare
    assign take_r   = rc_ok && (rd_rec.key < best_reg.key);
    assign fin_rec  = take_r ? rd_rec : best_reg;
    assign fin_pick = take_r ? rc[AW-1:0] : pick_reg;

    assign status.last_acc = in_acc && records.is_last;
    assign status.i_zero   = (i_reg == '0);
    assign status.no_lc    = lc >= {1'b0, len_reg};
    assign status.move     = (fin_pick != pos_reg);
    assign status.busy     = out_valid_reg && !sorted.ready;
    assign status.more     = (k_inc != count_reg);

    // read address select
    always_comb
    begin
        case (uword.addr)
            hsd_pkg::ADDR_I_DEC: ram_raddr = i_dec[AW-1:0];
            hsd_pkg::ADDR_ZERO:  ram_raddr = '0;
            hsd_pkg::ADDR_LC:    ram_raddr = lc[AW-1:0];
            hsd_pkg::ADDR_RC:    ram_raddr = rc[AW-1:0];
            hsd_pkg::ADDR_K:     ram_raddr = k_reg;
            default:             ram_raddr = '0;
        endcase
    end

    // datapath operations
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = cur_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        // a taken result frees the output register
        if (sorted.valid && sorted.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (uword.op)
            hsd_pkg::OP_LOAD:
            begin
                if (in_acc)
                begin
                    if (room)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = in_rec;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            hsd_pkg::OP_I_HALF:
            begin
                i_next = count_reg >> 1;
            end
            hsd_pkg::OP_BUILD_SETUP:
            begin
                pos_next = i_dec[AW-1:0];
                len_next = count_reg;
                i_next   = i_dec;
            end
            hsd_pkg::OP_LD_CUR:
            begin
                cur_next = rd_rec;
            end
            hsd_pkg::OP_I_ALL:
            begin
                i_next = count_reg;
            end
            hsd_pkg::OP_LD_ROOT:
            begin
                best_next = rd_rec;
            end
            hsd_pkg::OP_SWAP:
            begin
                // old root goes to the end of the region, old end is sifted from the root
                ram_we    = 1'b1;
                ram_waddr = i_dec[AW-1:0];
                ram_wdata = best_reg;
                cur_next  = rd_rec;
                pos_next  = '0;
                len_next  = i_dec;
                i_next    = i_dec;
            end
            hsd_pkg::OP_K_CLR:
            begin
                k_next = '0;
            end
            hsd_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_rec_next   = rd_rec;
                out_last_next  = !status.more;
                out_ovf_next   = ovf_reg;
                if (status.more)
                begin
                    k_next = k_inc[AW-1:0];
                end
            end
            hsd_pkg::OP_FINISH:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            hsd_pkg::OP_PICK_L:
            begin
                // strict less-than keeps the parent on ties
                if (rd_rec.key < cur_reg.key)
                begin
                    best_next = rd_rec;
                    pick_next = lc[AW-1:0];
                end
                else
                begin
                    best_next = cur_reg;
                    pick_next = pos_reg;
                end
            end
            hsd_pkg::OP_PICK_R:
            begin
                // smaller child moves up, the sifted record follows down
                if (status.move)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = fin_rec;
                    pos_next  = fin_pick;
                end
            end
            hsd_pkg::OP_WR_CUR:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        k_reg        <= k_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign sorted.valid      = out_valid_reg;
    assign sorted.sorted_key = out_rec_reg.key;
    assign sorted.sorted_tag = out_rec_reg.tag;
    assign sorted.last_out   = out_last_reg;
    assign sorted.overflowed = out_ovf_reg;

    // the set never grows past the memory
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("record count past depth");

    // every memory write lands inside the memory
    a_waddr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (int'(ram_waddr) < DEPTH))
        else $error("memory write out of range");

    // a closing record stops loading until the run is out
    a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.ready && records.is_last) |=> !records.ready)
        else $error("input still ready after last record");

    // a result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (uword.op == hsd_pkg::OP_EMIT) |-> !out_valid_reg)
        else $error("pending result overwritten");

endmodule
